### rtl/vks_pkg.sv
// ----------------------------------------------------------------------------
// vks_pkg
// Shared types and constants for the vector keyframe sampler.
// ----------------------------------------------------------------------------
package vks_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        key_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [31:0]        sample_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [31:0] ktime;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
    } t_key;

    typedef struct packed {
        logic go;
        logic op;
    } t_mdu_ctl;

endpackage

### rtl/vks_mdu.sv
// ----------------------------------------------------------------------------
// vks_mdu
// Shared bit-serial unit: restoring divide (49 by 33 bits, 49 steps) or
// shift-add multiply (49 by 33 bits, 33 steps) on one 50-bit adder.
// ----------------------------------------------------------------------------
module vks_mdu
    import vks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mdu_ctl    i_ctl,
    input  logic [48:0] i_a,      // dividend or multiplicand
    input  logic [32:0] i_b,      // divisor or multiplier
    output logic        o_done,
    output logic [49:0] o_hi,
    output logic [48:0] o_lo
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [49:0] r_acc, n_acc;
    logic [48:0] r_lo, n_lo;
    logic [48:0] r_opnd, n_opnd;

    logic [49:0] add_x, add_y, sum;
    logic        sub;

    // one adder shared by both operations
    always_comb begin
        sub   = (r_op == OP_DIV);
        add_x = sub ? {16'd0, r_acc[32:0], r_lo[48]} : r_acc;
        add_y = sub ? {1'b0, r_opnd} : (r_lo[0] ? {1'b0, r_opnd} : 50'd0);
        sum   = add_x + (sub ? ~add_y : add_y) + {49'd0, sub};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_lo   = r_lo;
        n_opnd = r_opnd;
        if (i_ctl.go) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_acc  = '0;
            n_opnd = (i_ctl.op == OP_DIV) ? {16'd0, i_b} : i_a;
            n_lo   = (i_ctl.op == OP_DIV) ? i_a : {16'd0, i_b};
            n_cnt  = (i_ctl.op == OP_DIV) ? 6'd49 : 6'd33;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                n_acc = sum[49] ? add_x : sum;
                n_lo  = {r_lo[47:0], ~sum[49]};
            end else begin
                n_acc = {1'b0, sum[49:1]};
                n_lo  = {16'd0, sum[0], r_lo[32:1]};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_lo   <= n_lo;
        r_opnd <= n_opnd;
    end

    assign o_done = r_done;
    assign o_hi   = r_acc;
    assign o_lo   = r_lo;

endmodule

### rtl/vector_keyframe_sampler_core.sv
// clear and append leave the state machine idle, so busy stays low; a sample on an
// empty track gives its word on the next cycle, on a single-key track once S_RDS, S_RDE read it.
// other samples scan 1 to n-1 keys (S_SRCH, S_SCHK per key, one memory read port), then
// read the segment keys (S_RDS, S_RDE, S_CAPE), set up in S_PREP, run the serial divide and
// one multiply per component (S_MSET, S_MUL); a zero-length segment ends in S_PREP.
// result strobe lasts one cycle, cannot be stalled; sync active-low reset empties track.
// ----------------------------------------------------------------------------
// vector_keyframe_sampler_core
// Keyframe track with linear interpolation of a three-component vector.
// ----------------------------------------------------------------------------
module vector_keyframe_sampler_core
    import vks_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_SCHK = 4'd2;
    localparam logic [3:0] S_RDS  = 4'd3;
    localparam logic [3:0] S_RDE  = 4'd4;
    localparam logic [3:0] S_CAPE = 4'd5;
    localparam logic [3:0] S_PREP = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_MSET = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;

    t_key r_mem [0:MAX_KEYS-1];
    t_key r_rd;
    logic [KEY_AW-1:0] rd_addr;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [KEY_AW-1:0] r_idx, n_idx;
    logic [KEY_AW-1:0] r_seg, n_seg;
    logic              r_single, n_single;
    logic [31:0]       r_t, n_t;
    t_key              r_start, n_start;
    t_key              r_end, n_end;
    logic [48:0]       r_fm, n_fm;
    logic              r_fneg, n_fneg;
    logic              r_neg, n_neg;
    logic [1:0]        r_comp, n_comp;
    logic              r_valid, n_valid;
    t_out_item         r_res, n_res;

    t_mdu_ctl    mdu_ctl;
    logic [48:0] mdu_a;
    logic [32:0] mdu_b;
    logic        mdu_done;
    logic [49:0] mdu_hi;
    logic [48:0] mdu_lo;

    logic        accept;
    logic [32:0] delta, num, dmag, nmag;
    logic [31:0] s_comp, e_comp;
    logic [32:0] d_comp, d_mag;
    logic [81:0] prod;
    logic        over;
    logic [35:0] r_sum;
    logic [31:0] sat;

    vks_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mdu_ctl),
        .i_a     (mdu_a),
        .i_b     (mdu_b),
        .o_done  (mdu_done),
        .o_hi    (mdu_hi),
        .o_lo    (mdu_lo)
    );

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept && i_item.action == ACT_APPEND && r_count < CNT_W'(MAX_KEYS)) begin
            r_mem[r_count[KEY_AW-1:0]] <= '{ktime: i_item.key_time,
                                             kx: i_item.value_x,
                                             ky: i_item.value_y,
                                             kz: i_item.value_z};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        s_comp = r_start.kx;
        e_comp = r_end.kx;
        case (r_comp)
            2'd1:    begin s_comp = r_start.ky; e_comp = r_end.ky; end
            2'd2:    begin s_comp = r_start.kz; e_comp = r_end.kz; end
            default: begin s_comp = r_start.kx; e_comp = r_end.kx; end
        endcase
        delta  = {1'b0, r_end.ktime} - {1'b0, r_start.ktime};
        num    = {1'b0, r_t} - {1'b0, r_start.ktime};
        dmag   = delta[32] ? -delta : delta;
        nmag   = num[32] ? -num : num;
        d_comp = {e_comp[31], e_comp} - {s_comp[31], s_comp};
        d_mag  = d_comp[32] ? -d_comp : d_comp;
        prod   = {mdu_hi[48:0], mdu_lo[32:0]};
        over   = (prod[81:16] > 66'h4_0000_0000)
              || (prod[81:16] == 66'h4_0000_0000 && prod[15:0] != 16'd0);
        r_sum  = r_neg ? {{4{s_comp[31]}}, s_comp} - {1'b0, prod[50:16]}
                       : {{4{s_comp[31]}}, s_comp} + {1'b0, prod[50:16]};
        if (over)
            sat = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        else if (r_sum[35:31] != 5'b00000 && r_sum[35:31] != 5'b11111)
            sat = r_sum[35] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            sat = r_sum[31:0];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_seg    = r_seg;
        n_single = r_single;
        n_t      = r_t;
        n_start  = r_start;
        n_end    = r_end;
        n_fm     = r_fm;
        n_fneg   = r_fneg;
        n_neg    = r_neg;
        n_comp   = r_comp;
        n_valid  = 1'b0;
        n_res    = r_res;
        rd_addr  = r_idx;
        mdu_ctl  = '{go: 1'b0, op: OP_DIV};
        mdu_a    = {nmag, 16'd0};
        mdu_b    = dmag;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.action)
                        ACT_CLEAR: n_count = '0;
                        ACT_APPEND: begin
                            if (r_count < CNT_W'(MAX_KEYS))
                                n_count = r_count + CNT_W'(1);
                        end
                        ACT_SAMPLE: begin
                            n_t = i_item.sample_time;
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_res   = '{out_x: '0, out_y: '0, out_z: '0,
                                            status: ST_EMPTY};
                            end else if (r_count == CNT_W'(1)) begin
                                n_single = 1'b1;
                                n_seg    = '0;
                                n_state  = S_RDS;
                            end else begin
                                n_single = 1'b0;
                                n_idx    = KEY_AW'(1);
                                n_state  = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH: begin
                rd_addr = r_idx;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_t < r_rd.ktime) begin
                    n_seg   = r_idx - KEY_AW'(1);
                    n_state = S_RDS;
                end else if ({1'b0, r_idx} + CNT_W'(1) == r_count) begin
                    // no segment holds the time: fall back to the first
                    n_seg   = '0;
                    n_state = S_RDS;
                end else begin
                    n_idx   = r_idx + KEY_AW'(1);
                    n_state = S_SRCH;
                end
            end
            S_RDS: begin
                rd_addr = r_seg;
                n_state = S_RDE;
            end
            S_RDE: begin
                rd_addr = r_seg + KEY_AW'(1);
                n_start = r_rd;
                if (r_single) begin
                    n_valid = 1'b1;
                    n_res   = '{out_x: r_rd.kx, out_y: r_rd.ky, out_z: r_rd.kz,
                                status: ST_OK};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CAPE;
                end
            end
            S_CAPE: begin
                n_end   = r_rd;
                n_state = S_PREP;
            end
            S_PREP: begin
                if (delta == '0) begin
                    n_valid = 1'b1;
                    n_res   = '{out_x: r_start.kx, out_y: r_start.ky,
                                out_z: r_start.kz, status: ST_ZERO};
                    n_state = S_IDLE;
                end else begin
                    mdu_ctl = '{go: 1'b1, op: OP_DIV};
                    n_fneg  = num[32] ^ delta[32];
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (mdu_done) begin
                    n_fm    = mdu_lo;
                    n_comp  = 2'd0;
                    n_state = S_MSET;
                end
            end
            S_MSET: begin
                mdu_ctl = '{go: 1'b1, op: OP_MUL};
                mdu_a   = r_fm;
                mdu_b   = d_mag;
                n_neg   = d_comp[32] ^ r_fneg;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mdu_done) begin
                    n_res.status = ST_OK;
                    case (r_comp)
                        2'd0:    n_res.out_x = sat;
                        2'd1:    n_res.out_y = sat;
                        default: n_res.out_z = sat;
                    endcase
                    if (r_comp == 2'd2) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = S_MSET;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_seg    <= n_seg;
        r_single <= n_single;
        r_t      <= n_t;
        r_start  <= n_start;
        r_end    <= n_end;
        r_fm     <= n_fm;
        r_fneg   <= n_fneg;
        r_neg    <= n_neg;
        r_comp   <= n_comp;
        r_res    <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count beyond track size");

    a_no_word_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.action != ACT_SAMPLE |=> !o_valid)
        else $error("word strobed after clear or append");

    a_mdu_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_done |-> (r_state == S_DIV || r_state == S_MUL))
        else $error("arithmetic unit finished outside a wait state");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy || $past(r_state) == S_IDLE)
        else $error("word strobed while sample still running");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, append and sample words into the keyframe sampler and checks
// every interpolated result against a local model of the track.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import vks_pkg::*;

    class track_scoreboard;
        logic [31:0] key_t [MAX_KEYS];
        logic [31:0] key_x [MAX_KEYS];
        logic [31:0] key_y [MAX_KEYS];
        logic [31:0] key_z [MAX_KEYS];
        int          key_cnt;
        t_out_item   pending_q [$];
        int          errors;
        int          checked;
        int          zero_seg_cnt;
        int          empty_cnt;

        function new();
            key_cnt = 0;
            errors = 0;
            checked = 0;
            zero_seg_cnt = 0;
            empty_cnt = 0;
        endfunction

        function logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                    longint factor);
            longint s, d, r, sc;
            bit neg;
            longint unsigned dm, fm;
            s = longint'($signed(a));
            d = longint'($signed(b)) - s;
            neg = (d < 0) != (factor < 0);
            dm = (d < 0) ? -d : d;
            fm = (factor < 0) ? -factor : factor;
            if (dm == 0 || fm == 0) begin
                r = s;
            end else if (dm > (64'd1 << 50) / fm) begin
                r = neg ? -(64'sd1 << 40) : (64'sd1 << 40);
            end else begin
                sc = longint'((dm * fm) >> 16);
                r = s + (neg ? -sc : sc);
            end
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_word(t_in_item w);
            t_out_item e;
            int seg;
            longint delta, num, factor;
            longint unsigned nm, dm, qm;
            logic [31:0] t;
            case (w.action)
                ACT_CLEAR: key_cnt = 0;
                ACT_APPEND: begin
                    if (key_cnt < MAX_KEYS) begin
                        key_t[key_cnt] = w.key_time;
                        key_x[key_cnt] = w.value_x;
                        key_y[key_cnt] = w.value_y;
                        key_z[key_cnt] = w.value_z;
                        key_cnt++;
                    end
                end
                ACT_SAMPLE: begin
                    e = '0;
                    if (key_cnt == 0) begin
                        e.status = ST_EMPTY;
                        empty_cnt++;
                    end else if (key_cnt == 1) begin
                        e.out_x = key_x[0];
                        e.out_y = key_y[0];
                        e.out_z = key_z[0];
                        e.status = ST_OK;
                    end else begin
                        t = w.sample_time;
                        seg = 0;
                        for (int i = 0; i + 1 < key_cnt; i++) begin
                            if (t < key_t[i+1]) begin
                                seg = i;
                                break;
                            end
                        end
                        delta = longint'({32'd0, key_t[seg+1]})
                              - longint'({32'd0, key_t[seg]});
                        if (delta == 0) begin
                            e.out_x = key_x[seg];
                            e.out_y = key_y[seg];
                            e.out_z = key_z[seg];
                            e.status = ST_ZERO;
                            zero_seg_cnt++;
                        end else begin
                            num = longint'({32'd0, t}) - longint'({32'd0, key_t[seg]});
                            nm = (num < 0) ? -num : num;
                            dm = (delta < 0) ? -delta : delta;
                            qm = (nm << 16) / dm;
                            factor = ((num < 0) != (delta < 0)) ? -longint'(qm)
                                                                : longint'(qm);
                            e.out_x = blend(key_x[seg], key_x[seg+1], factor);
                            e.out_y = blend(key_y[seg], key_y[seg+1], factor);
                            e.out_z = blend(key_z[seg], key_z[seg+1], factor);
                            e.status = ST_OK;
                        end
                    end
                    pending_q.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending_q.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (got.out_x !== e.out_x) begin
                $error("out_x expected %h actual %h", e.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== e.out_y) begin
                $error("out_y expected %h actual %h", e.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== e.out_z) begin
                $error("out_z expected %h actual %h", e.out_z, got.out_z);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    track_scoreboard sb;
    bit quiet_stretch;
    int words_sent;

    vector_keyframe_sampler_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // outputs are stable mid-cycle, so sample there
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_result);
        end
    end

    // hold start until the word is taken, then sometimes a random idle gap
    task automatic send_word(t_in_item w);
        bit taken;
        start <= 1'b1;
        i_item <= w;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy && i_rst_n;
            @(posedge i_clk);
        end
        sb.note_word(w);
        words_sent++;
        if (!quiet_stretch && $urandom_range(99) < 13) begin
            start <= 1'b0;
            i_item <= t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  2'($urandom)});
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_in_item mk(logic [1:0] act, logic [31:0] kt,
                                   logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic [31:0] st);
        t_in_item w;
        w.action = act;
        w.key_time = kt;
        w.value_x = x;
        w.value_y = y;
        w.value_z = z;
        w.sample_time = st;
        return w;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((sb.pending_q.size() != 0 || busy) && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        logic [31:0] tcur;
        int nkeys;
        sb = new();
        words_sent = 0;
        quiet_stretch = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, single key, zero segment, extrapolation, overflow
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'h1234));
        send_word(mk(ACT_APPEND, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 5, 0));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'hffff_ffff));
        send_word(mk(ACT_APPEND, 32'h0001_0000, 1, 2, 3, 0));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 0));
        send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
        send_word(mk(ACT_APPEND, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
        send_word(mk(ACT_APPEND, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000,
                     32'h0001_0000, 0));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'hffff_ffff));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 0));
        send_word(mk(3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, 32'hffff_ffff));
        send_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
        send_word(mk(ACT_APPEND, 32'h0010_0000, 100, 200, 300, 0));
        send_word(mk(ACT_APPEND, 32'h0002_0000, -100, 0, 32'h4000_0000, 0));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'h0008_0000));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'hffff_ffff));
        // fill the track past full so appends are dropped
        for (int i = 0; i < MAX_KEYS; i++) begin
            send_word(mk(ACT_APPEND, 32'(i) << 20, $urandom, $urandom, $urandom, 0));
        end
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'hffff_ffff));
        send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, 32'h03f8_0000));
        // pause until every result is back
        drain();

        while (words_sent < 1500) begin
            quiet_stretch = (words_sent > 700 && words_sent < 900);
            if ($urandom_range(9) == 0) begin
                send_word(t_in_item'({$urandom, $urandom, $urandom, $urandom,
                                      $urandom, 2'($urandom)}));
            end else begin
                // well-formed track, mostly short, sometimes long or full
                send_word(mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
                nkeys = ($urandom_range(19) == 0) ? $urandom_range(40, MAX_KEYS + 2)
                                                  : $urandom_range(0, 6);
                tcur = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
                for (int k = 0; k < nkeys; k++) begin
                    send_word(mk(ACT_APPEND, tcur, rand_val(), rand_val(), rand_val(),
                                 $urandom));
                    case ($urandom_range(7))
                        0: tcur = tcur;
                        1: tcur = $urandom;
                        default: tcur = tcur + $urandom_range(1, 1 << $urandom_range(1, 24));
                    endcase
                end
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(3))
                        0: send_word(mk(ACT_SAMPLE, $urandom, $urandom, $urandom,
                                        $urandom, $urandom));
                        1: send_word(mk(ACT_SAMPLE, 0, 0, 0, 0, tcur));
                        default: send_word(mk(ACT_SAMPLE, 0, 0, 0, 0,
                                              tcur - $urandom_range(0, 1 << 16)));
                    endcase
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d words, %0d results checked (%0d empty, %0d zero-length)",
                 words_sent, sb.checked, sb.empty_cnt, sb.zero_seg_cnt);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
